// ===== design/rptr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptr_pkg: shared types and constants of the reader progress rank tracker
// Field widths, default store sizes, command codes, controller states and the
// status bundle of the serial divider.
// ----------------------------------------------------------------------------
package rptr_pkg;

  // Field widths of one input beat and one result beat
  localparam int UID_W   = 12;
  localparam int PG_W    = 10;
  localparam int SHARE_W = 17;

  localparam int IN_TDATA_W  = 24;  // user_id + pages_read, padded to bytes
  localparam int OUT_TDATA_W = 32;  // user_id_echo + rank_fraction, padded

  // Default store sizes
  localparam int DEF_USER_SLOTS = 4096;
  localparam int DEF_PAGE_SLOTS = 1024;
  localparam int DEF_CNT_W      = $clog2(DEF_USER_SLOTS + 1);

  // 1.0 in Q1.16
  localparam logic [SHARE_W-1:0] FULL_SHARE = 17'h10000;

  typedef enum logic [0:0] {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_USER,
    ST_DEC,
    ST_INC_RD,
    ST_INC,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/reader_progress_rank_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_progress_rank_tracker: per-user page counts and percentile rank
// Keeps each user's page count, a histogram of users per page count and the
// number of known users; answers a query with the share of other users that
// have read fewer pages, in Q1.16.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tuser: command; tdata: user_id[11:0], pages_read[21:12]
//  m_axis    out        tdata: user_id_echo[11:0], rank_fraction[28:12]
//
//  Per accepted beat: an update is dropped when invalid, enters a first
//  sighting into its new bin, or moves the user from the old bin to the
//  new one. A query sums the bins below the user's stored page count: the
//  histogram memory port reads one bin per cycle for the sum, then the serial
//  divider retires one quotient bit per cycle. Short-cut queries skip both.
//  Reset: a clearing pass over max(USER_SLOTS, PAGE_SLOTS) addresses (4096
//  at the defaults) zeroes both memories; no beat is accepted until it ends.
//  Stalls: a result waits in the output register, and the next beat is taken
//  meanwhile; only a second result holds the controller until the first is
//  taken.
// ----------------------------------------------------------------------------
module reader_progress_rank_tracker
  import rptr_pkg::*;
#(
  parameter int USER_SLOTS = DEF_USER_SLOTS,
  parameter int PAGE_SLOTS = DEF_PAGE_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // user_id[11:0], pages_read[21:12]
  input  logic [0:0]             s_axis_tuser,   // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // user_id_echo[11:0], rank_fraction[28:12]
);

  localparam int UIdxW   = $clog2(USER_SLOTS);
  localparam int HIdxW   = $clog2(PAGE_SLOTS);
  localparam int CntW    = $clog2(USER_SLOTS + 1);
  localparam int ClrLen  = (USER_SLOTS > PAGE_SLOTS) ? USER_SLOTS : PAGE_SLOTS;
  localparam int ClrW    = $clog2(ClrLen);
  localparam int PadW    = OUT_TDATA_W - UID_W - SHARE_W;

  // Controller state
  state_e state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic [CntW-1:0] known_q, known_d;
  logic            out_vld_q, out_vld_d;

  // Item and working registers (payload, no reset)
  cmd_e               cmd_q, cmd_d;
  logic [UID_W-1:0]   uid_q, uid_d;
  logic [PG_W-1:0]    pg_q, pg_d;
  logic [PG_W-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    fewer_q, fewer_d;
  logic [SHARE_W-1:0] res_q, res_d;
  logic [UID_W-1:0]   out_uid_q, out_uid_d;
  logic [SHARE_W-1:0] out_frac_q, out_frac_d;

  // User progress memory
  logic [PG_W-1:0]  umem [USER_SLOTS];
  logic             user_we, user_re;
  logic [UIdxW-1:0] user_wa, user_ra;
  logic [PG_W-1:0]  user_wd, user_rd_q;

  // Histogram memory
  logic [CntW-1:0]  hmem [PAGE_SLOTS];
  logic             hist_we, hist_re;
  logic [HIdxW-1:0] hist_wa, hist_ra;
  logic [CntW-1:0]  hist_wd, hist_rd_q;

  // Divider
  logic               div_start;
  div_stat_t          div_stat;
  logic [SHARE_W-1:0] div_quo;

  logic in_acc;
  logic uid_bad;
  logic upd_bad;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign uid_bad = int'(uid_q) >= USER_SLOTS;
  assign upd_bad = (pg_q == '0) || (int'(pg_q) >= PAGE_SLOTS) || uid_bad;

  // Memories: one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (user_we) begin
      umem[user_wa] <= user_wd;
    end
    if (user_re) begin
      user_rd_q <= umem[user_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hmem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_q <= hmem[hist_ra];
    end
  end

  rptr_div #(
    .CNT_W (CntW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fewer_q),
    .den_i   (known_q - CntW'(1)),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // Next state and memory controls.
  // user_rd_q holds the user's previous page count for the whole item: the
  // user memory is read only when a beat is accepted.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    known_d    = known_q;
    out_vld_d  = out_vld_q;
    cmd_d      = cmd_q;
    uid_d      = uid_q;
    pg_d       = pg_q;
    idx_d      = idx_q;
    fewer_d    = fewer_q;
    res_d      = res_q;
    out_uid_d  = out_uid_q;
    out_frac_d = out_frac_q;

    user_we = 1'b0;
    user_wa = UIdxW'(uid_q);
    user_wd = pg_q;
    user_re = 1'b0;
    user_ra = UIdxW'(s_axis_tdata[UID_W-1:0]);
    hist_we = 1'b0;
    hist_wa = HIdxW'(user_rd_q);
    hist_wd = '0;
    hist_re = 1'b0;
    hist_ra = HIdxW'(pg_q);

    div_start     = 1'b0;
    s_axis_tready = 1'b0;

    // drop the result once the sink takes it
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // sweep both memories; the smaller one simply wraps and rewrites zeros
        user_we = 1'b1;
        user_wa = UIdxW'(clr_q);
        user_wd = '0;
        hist_we = 1'b1;
        hist_wa = HIdxW'(clr_q);
        hist_wd = '0;
        clr_d   = clr_q + ClrW'(1);
        if (clr_q == ClrW'(ClrLen - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          uid_d   = s_axis_tdata[UID_W-1:0];
          pg_d    = s_axis_tdata[UID_W+PG_W-1:UID_W];
          user_re = 1'b1;
          state_d = ST_USER;
        end
      end

      ST_USER: begin
        if (cmd_q == CMD_UPDATE) begin
          if (upd_bad) begin
            state_d = ST_IDLE;
          end else begin
            user_we = 1'b1;
            if (user_rd_q == '0) begin
              // first sighting: count the user, go straight to the new bin
              known_d = known_q + CntW'(1);
              hist_re = 1'b1;
              hist_ra = HIdxW'(pg_q);
              state_d = ST_INC;
            end else begin
              hist_re = 1'b1;
              hist_ra = HIdxW'(user_rd_q);
              state_d = ST_DEC;
            end
          end
        end else begin
          fewer_d = '0;
          if (uid_bad || user_rd_q == '0) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else if (known_q <= CntW'(1)) begin
            res_d   = FULL_SHARE;
            state_d = ST_OUT;
          end else if (user_rd_q == PG_W'(1)) begin
            state_d = ST_DIV_GO;
          end else begin
            // start the bin sweep at page count one
            hist_re = 1'b1;
            hist_ra = HIdxW'(1);
            idx_d   = PG_W'(2);
            state_d = ST_SUM;
          end
        end
      end

      ST_DEC: begin
        // take the user out of the old bin
        hist_we = 1'b1;
        hist_wa = HIdxW'(user_rd_q);
        hist_wd = (hist_rd_q != '0) ? hist_rd_q - CntW'(1) : hist_rd_q;
        state_d = ST_INC_RD;
      end

      ST_INC_RD: begin
        // read the new bin only after the old one is written back
        hist_re = 1'b1;
        hist_ra = HIdxW'(pg_q);
        state_d = ST_INC;
      end

      ST_INC: begin
        hist_we = 1'b1;
        hist_wa = HIdxW'(pg_q);
        hist_wd = hist_rd_q + CntW'(1);
        state_d = ST_IDLE;
      end

      ST_SUM: begin
        // add the bin read last cycle, issue the next one
        fewer_d = fewer_q + hist_rd_q;
        if (idx_q == user_rd_q) begin
          state_d = ST_DIV_GO;
        end else begin
          hist_re = 1'b1;
          hist_ra = HIdxW'(idx_q);
          idx_d   = idx_q + PG_W'(1);
        end
      end

      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = div_quo;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_uid_d  = uid_q;
          out_frac_d = res_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      known_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      known_q   <= known_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    uid_q      <= uid_d;
    pg_q       <= pg_d;
    idx_q      <= idx_d;
    fewer_q    <= fewer_d;
    res_q      <= res_d;
    out_uid_q  <= out_uid_d;
    out_frac_q <= out_frac_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {PadW'(0), out_frac_q, out_uid_q};

  a_hist_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_we && hist_re && hist_wa == hist_ra))
    else $error("histogram read and write hit the same bin");

  a_accept_reads_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_USER)
    else $error("accepted beat did not reach the user lookup");

  a_known_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q >= $past(known_q))
    else $error("known user count went down");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside the wait state");

endmodule

// ===== design/rptr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptr_div: serial Q1.16 share divider
// Restoring division of num * 2^16 by den, one quotient bit per cycle,
// quotient clamped to 1.0.
// ----------------------------------------------------------------------------
module rptr_div
  import rptr_pkg::*;
#(
  parameter int CNT_W = DEF_CNT_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CNT_W-1:0]   num_i,
  input  logic [CNT_W-1:0]   den_i,
  output div_stat_t          stat_o,
  output logic [SHARE_W-1:0] quo_o
);

  localparam int W   = CNT_W + 16;
  localparam int StW = $clog2(W + 1);

  logic [W-1:0]     rq_q, rq_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] den_q, den_d;
  logic [StW-1:0]   cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [CNT_W:0]   rem_ext;
  logic [CNT_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_ext = {rem_q, rq_q[W-1]};
    rem_sub = rem_ext - {1'b0, den_q};
    ge      = rem_ext >= {1'b0, den_q};
    rq_d    = rq_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rq_d   = {num_i, 16'h0000};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = StW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? rem_sub[CNT_W-1:0] : rem_ext[CNT_W-1:0];
      rq_d  = {rq_q[W-2:0], ge};
      cnt_d = cnt_q - StW'(1);
      if (cnt_q == StW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q  <= rq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o = (rq_q > W'(FULL_SHARE)) ? FULL_SHARE : rq_q[SHARE_W-1:0];

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");

endmodule
